// ----- sv/wirl_pkg.sv -----
// Shared constants, types and codes of the windowed IP rate limiter.
package wirl_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int BAN_ENTRIES   = 256;
  localparam int WINDOW_DEPTH  = 4096;

  localparam int TIDX_W = $clog2(TABLE_ENTRIES);
  localparam int BIDX_W = $clog2(BAN_ENTRIES);
  localparam int WIDX_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAN       = 2'd2;

  localparam logic [15:0] THRESHOLD_RESET = 16'd10;
  localparam logic [15:0] WINDOW_RESET    = 16'd60;
  localparam logic [15:0] BAN_RESET       = 16'd60;

  typedef struct packed {
    logic        op;
    logic [31:0] client_ip;
    logic [31:0] access_time;
  } in_t;

  typedef struct packed {
    logic        dropped;
    logic        ban_imposed;
    logic [15:0] access_count;
    logic        table_full;
    logic [12:0] expired_count;
    logic [31:0] current_time;
  } res_t;

  typedef struct packed {
    logic [15:0] access_threshold;
    logic [15:0] window_seconds;
    logic [15:0] ban_seconds;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] ip;
    logic [15:0] val;
  } cnt_ent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] expiry;
  } ban_ent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] ts;
  } fifo_ent_t;

endpackage

// ----- sv/wirl_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module wirl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/wirl_ctrl.sv -----
// Sequencer that reads, updates and writes back the counter, ban and window memories.
module wirl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  wirl_pkg::in_t  item,
  input  wirl_pkg::cfg_t cfg,
  input  logic          out_free,
  output logic          idle,
  output logic          res_valid,
  output wirl_pkg::res_t res
);
  import wirl_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_BAN     = 14'b00000000000100,
    S_HASH    = 14'b00000000001000,
    S_HOME    = 14'b00000000010000,
    S_CNT_RD  = 14'b00000000100000,
    S_CNT_CHK = 14'b00000001000000,
    S_FIFO    = 14'b00000010000000,
    S_TKCHK   = 14'b00000100000000,
    S_FRD     = 14'b00001000000000,
    S_FWAIT   = 14'b00010000000000,
    S_ENQ     = 14'b00100000000000,
    S_BANW    = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [TIDX_W-1:0] clr_r, clr_nxt;
  logic [31:0] now_r, now_nxt;
  logic [WIDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [BAN_ENTRIES-1:0] ban_vld_r, ban_vld_nxt;
  logic scan_on_r, scan_on_nxt, proc_v_r, proc_v_nxt;

  logic [31:0] ip_r, ip_nxt, ts_r, ts_nxt, key_r, key_nxt, prod_r, prod_nxt;
  logic tick_r, tick_nxt, lk_pop_r, lk_pop_nxt;
  logic [TIDX_W-1:0] pos_r, pos_nxt, probes_r, probes_nxt, slot_r, slot_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [BIDX_W-1:0] scan_k_r, scan_k_nxt, proc_idx_r, proc_idx_nxt;
  logic proc_last_r, proc_last_nxt;
  logic banned_r, banned_nxt, mfound_r, mfound_nxt, ffound_r, ffound_nxt;
  logic [BIDX_W-1:0] mslot_r, mslot_nxt, fslot_r, fslot_nxt;
  res_t res_r, res_nxt;

  logic cnt_we;
  logic [TIDX_W-1:0] cnt_waddr;
  cnt_ent_t cnt_wdata, cnt_rdata;
  logic ban_we;
  logic [BIDX_W-1:0] ban_waddr;
  ban_ent_t ban_wdata, ban_rdata;
  logic fifo_we;
  fifo_ent_t fifo_wdata, fifo_rdata;

  logic [31:0] hmix;
  logic b_match, b_hit, b_free, b_vld;
  logic [32:0] exp_sum, win_sum;
  logic pop_done;

  wirl_ram #(.WIDTH($bits(cnt_ent_t)), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(pos_r), .rdata(cnt_rdata)
  );

  wirl_ram #(.WIDTH($bits(ban_ent_t)), .DEPTH(BAN_ENTRIES)) u_ban_ram (
    .clk(clk), .we(ban_we), .waddr(ban_waddr), .wdata(ban_wdata),
    .raddr(scan_k_r), .rdata(ban_rdata)
  );

  wirl_ram #(.WIDTH($bits(fifo_ent_t)), .DEPTH(WINDOW_DEPTH)) u_fifo_ram (
    .clk(clk), .we(fifo_we), .waddr(tail_r), .wdata(fifo_wdata),
    .raddr(head_r), .rdata(fifo_rdata)
  );

  assign hmix    = prod_r ^ (prod_r >> 16);
  assign b_vld   = ban_vld_r[proc_idx_r];
  assign b_match = b_vld && (ban_rdata.ip == ip_r);
  assign b_hit   = b_match && (now_r < ban_rdata.expiry);
  assign b_free  = !b_vld || (now_r >= ban_rdata.expiry);
  assign exp_sum = {1'b0, now_r} + {17'd0, cfg.ban_seconds};
  assign win_sum = {1'b0, fifo_rdata.ts} + {17'd0, cfg.window_seconds};

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    now_nxt = now_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    ban_vld_nxt = ban_vld_r;
    scan_on_nxt = scan_on_r;
    proc_v_nxt = 1'b0;
    ip_nxt = ip_r;
    ts_nxt = ts_r;
    key_nxt = key_r;
    prod_nxt = prod_r;
    tick_nxt = tick_r;
    lk_pop_nxt = lk_pop_r;
    pos_nxt = pos_r;
    probes_nxt = probes_r;
    slot_nxt = slot_r;
    cnt_nxt = cnt_r;
    scan_k_nxt = scan_k_r;
    proc_idx_nxt = proc_idx_r;
    proc_last_nxt = proc_last_r;
    banned_nxt = banned_r;
    mfound_nxt = mfound_r;
    mslot_nxt = mslot_r;
    ffound_nxt = ffound_r;
    fslot_nxt = fslot_r;
    res_nxt = res_r;
    cnt_we = 1'b0;
    cnt_waddr = pos_r;
    cnt_wdata = '0;
    ban_we = 1'b0;
    ban_waddr = '0;
    ban_wdata = '0;
    fifo_we = 1'b0;
    fifo_wdata = '0;
    pop_done = 1'b0;

    case (state_r)
      S_CLEAR: begin
        cnt_we = 1'b1;
        cnt_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TIDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ip_nxt = item.client_ip;
          ts_nxt = item.access_time;
          tick_nxt = item.op;
          res_nxt = '0;
          if (item.op) begin
            now_nxt = now_r + 1'b1;
            res_nxt.current_time = now_r + 1'b1;
            state_nxt = S_TKCHK;
          end else begin
            res_nxt.current_time = now_r;
            scan_k_nxt = '0;
            scan_on_nxt = 1'b1;
            banned_nxt = 1'b0;
            mfound_nxt = 1'b0;
            ffound_nxt = 1'b0;
            state_nxt = S_BAN;
          end
        end
      end
      S_BAN: begin
        if (scan_on_r) begin
          proc_v_nxt = 1'b1;
          proc_idx_nxt = scan_k_r;
          proc_last_nxt = (scan_k_r == BIDX_W'(BAN_ENTRIES - 1));
          scan_k_nxt = scan_k_r + 1'b1;
          if (scan_k_r == BIDX_W'(BAN_ENTRIES - 1)) begin
            scan_on_nxt = 1'b0;
          end
        end
        if (proc_v_r) begin
          banned_nxt = banned_r || b_hit;
          if (b_match && !mfound_r) begin
            mfound_nxt = 1'b1;
            mslot_nxt = proc_idx_r;
          end
          if (b_free && !ffound_r) begin
            ffound_nxt = 1'b1;
            fslot_nxt = proc_idx_r;
          end
          if (proc_last_r) begin
            if (banned_r || b_hit) begin
              res_nxt.dropped = 1'b1;
              state_nxt = S_DONE;
            end else begin
              key_nxt = ip_r;
              lk_pop_nxt = 1'b0;
              state_nxt = S_HASH;
            end
          end
        end
      end
      S_HASH: begin
        prod_nxt = key_r * HASH_MULT;
        state_nxt = S_HOME;
      end
      S_HOME: begin
        pos_nxt = hmix[TIDX_W-1:0];
        probes_nxt = '0;
        state_nxt = S_CNT_RD;
      end
      S_CNT_RD: begin
        state_nxt = S_CNT_CHK;
      end
      S_CNT_CHK: begin
        if (!cnt_rdata.vld) begin
          if (lk_pop_r) begin
            pop_done = 1'b1;
          end else begin
            cnt_we = 1'b1;
            cnt_wdata = '{vld: 1'b1, ip: key_r, val: 16'd1};
            slot_nxt = pos_r;
            cnt_nxt = 16'd1;
            state_nxt = S_FIFO;
          end
        end else if (cnt_rdata.ip == key_r) begin
          cnt_wdata = cnt_rdata;
          if (lk_pop_r) begin
            if (cnt_rdata.val != 16'd0) begin
              cnt_we = 1'b1;
              cnt_wdata.val = cnt_rdata.val - 1'b1;
              if (!tick_r && pos_r == slot_r) begin
                cnt_nxt = cnt_rdata.val - 1'b1;
              end
            end
            pop_done = 1'b1;
          end else begin
            cnt_we = 1'b1;
            if (cnt_rdata.val != 16'hFFFF) begin
              cnt_wdata.val = cnt_rdata.val + 1'b1;
            end
            slot_nxt = pos_r;
            cnt_nxt = cnt_wdata.val;
            state_nxt = S_FIFO;
          end
        end else if (probes_r == TIDX_W'(TABLE_ENTRIES - 1)) begin
          if (lk_pop_r) begin
            pop_done = 1'b1;
          end else begin
            res_nxt.table_full = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          probes_nxt = probes_r + 1'b1;
          pos_nxt = (pos_r == TIDX_W'(TABLE_ENTRIES - 1)) ? '0 : pos_r + 1'b1;
          state_nxt = S_CNT_RD;
        end
        if (pop_done) begin
          head_nxt = (head_r == WIDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;
          fill_nxt = fill_r - 1'b1;
          if (tick_r) begin
            res_nxt.expired_count = res_r.expired_count + 1'b1;
            state_nxt = S_TKCHK;
          end else begin
            state_nxt = S_ENQ;
          end
        end
      end
      S_FIFO: begin
        if (fill_r == FILL_W'(WINDOW_DEPTH)) begin
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_ENQ;
        end
      end
      S_TKCHK: begin
        if (fill_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (!tick_r || win_sum < {1'b0, now_r}) begin
          key_nxt = fifo_rdata.ip;
          lk_pop_nxt = 1'b1;
          state_nxt = S_HASH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ENQ: begin
        fifo_we = 1'b1;
        fifo_wdata = '{ip: ip_r, ts: ts_r};
        tail_nxt = (tail_r == WIDX_W'(WINDOW_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        fill_nxt = fill_r + 1'b1;
        res_nxt.access_count = cnt_r;
        if (cnt_r >= cfg.access_threshold) begin
          state_nxt = S_BANW;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BANW: begin
        ban_wdata = '{ip: ip_r, expiry: exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0]};
        if (mfound_r || ffound_r) begin
          ban_we = 1'b1;
          ban_waddr = mfound_r ? mslot_r : fslot_r;
          ban_vld_nxt[ban_waddr] = 1'b1;
          res_nxt.ban_imposed = 1'b1;
        end else begin
          res_nxt.table_full = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      now_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      ban_vld_r <= '0;
      scan_on_r <= 1'b0;
      proc_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      now_r <= now_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      ban_vld_r <= ban_vld_nxt;
      scan_on_r <= scan_on_nxt;
      proc_v_r <= proc_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ip_r <= ip_nxt;
    ts_r <= ts_nxt;
    key_r <= key_nxt;
    prod_r <= prod_nxt;
    tick_r <= tick_nxt;
    lk_pop_r <= lk_pop_nxt;
    pos_r <= pos_nxt;
    probes_r <= probes_nxt;
    slot_r <= slot_nxt;
    cnt_r <= cnt_nxt;
    scan_k_r <= scan_k_nxt;
    proc_idx_r <= proc_idx_nxt;
    proc_last_r <= proc_last_nxt;
    banned_r <= banned_nxt;
    mfound_r <= mfound_nxt;
    mslot_r <= mslot_nxt;
    ffound_r <= ffound_nxt;
    fslot_r <= fslot_nxt;
    res_r <= res_nxt;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill exceeds depth");

  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    WIDX_W'(tail_r - head_r) == fill_r[WIDX_W-1:0])
    else $error("window pointers disagree with fill");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> (state_r == S_DONE))
    else $error("result left before output register was free");

  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res_r.dropped && (res_r.ban_imposed || res_r.access_count != 16'd0)))
    else $error("dropped beat also counted");
`endif

endmodule

// ----- sv/windowed_ip_rate_limiter.sv -----
// Top level of the windowed IP rate limiter: configuration registers, handshakes, output register.
// After reset all 1024 counter table entries are cleared, during which no beat is taken.
// A tick advances the current time, then, while the oldest window entry has expired, pops it
// and decrements its IP's counter, which it finds by following that IP's probe chain.
// An access scans all 256 entries of the ban memory through its single read port. Unless the IP
// is banned, it then hashes the IP and probes the counter memory and, unless the counter table is
// full, writes the window memory, evicting the oldest entry first when the window is full.
// A finished result waits in the output register while the next beat is already taken.
module windowed_ip_rate_limiter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wirl_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wirl_pkg::res_t                  out_data,
  input  logic                            cfg_we,
  input  logic [wirl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_wdata
);
  import wirl_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_data_r, out_data_nxt;
  logic idle, res_valid, out_free, start;
  res_t res;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !idle;
  assign start     = in_valid && idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  wirl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .item(in_data), .cfg(cfg_r),
    .out_free(out_free), .idle(idle), .res_valid(res_valid), .res(res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: cfg_nxt.access_threshold = cfg_wdata;
        REG_WINDOW:    cfg_nxt.window_seconds = cfg_wdata;
        REG_BAN:       cfg_nxt.ban_seconds = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{access_threshold: THRESHOLD_RESET, window_seconds: WINDOW_RESET,
                 ban_seconds: BAN_RESET};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
